/* hw/rtl/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions of the SM4 decryption block.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int SM4_ROUNDS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 64;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_KEY_EN   = 2'd2;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        last;
  } sm4_item_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        enable;
  } sm4_key_t;

  localparam logic [31:0] FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]} ^
           {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] lin_key(logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // CK byte j of word i is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(logic [4:0] i);
    logic [31:0] w;
    logic [7:0]  base;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return w;
  endfunction

endpackage

/* hw/rtl/sm4_front.sv */
// ----------------------------------------------------------------------------
// sm4_front
// Input side: accepts ciphertext beats into a short queue toward the engine.
// ----------------------------------------------------------------------------
module sm4_front #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sm4_pkg::sm4_item_t in_item_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output sm4_pkg::sm4_item_t item_o
);
  import sm4_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sm4_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_take_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

/* hw/rtl/sm4_engine.sv */
// ----------------------------------------------------------------------------
// sm4_engine
// Iterative SM4 datapath: key schedule into a round key memory, then 32
// decryption rounds per block, one round a cycle, into an output register.
// ----------------------------------------------------------------------------
module sm4_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sm4_pkg::sm4_key_t  key_i,
  input  logic               key_clear_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  sm4_pkg::sm4_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sm4_pkg::sm4_item_t out_item_o
);
  import sm4_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_KEYEXP = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  localparam logic [4:0] LastRound = 5'(SM4_ROUNDS - 1);

  state_e      state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        keys_ready_q, keys_ready_d;
  logic        out_valid_q, out_valid_d;
  logic [127:0] x_q, x_d, k_q, k_d;
  logic        last_q, last_d;
  sm4_item_t   out_q, out_d;
  logic [31:0] rk_mem [SM4_ROUNDS];
  logic [31:0] rk_q;
  logic [4:0]  rd_addr;
  logic        rk_we;
  logic [31:0] rk_wdata;
  logic [31:0] nx, nk;
  logic        out_free;

  assign nx = x_q[127:96] ^ lin_data(x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk_q);
  assign nk = k_q[127:96] ^ lin_key(k_q[95:64] ^ k_q[63:32] ^ k_q[31:0] ^ ck_word(cnt_q));
  assign rk_wdata = key_i.enable ? nk : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign item_take_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q;
    x_d          = x_q;
    k_d          = k_q;
    last_d       = last_q;
    out_d        = out_q;
    rd_addr      = '0;
    rk_we        = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          x_d    = {item_i.high, item_i.low};
          last_d = item_i.last;
          cnt_d  = '0;
          k_d    = {key_i.high[63:32] ^ FK[0], key_i.high[31:0] ^ FK[1],
                    key_i.low[63:32] ^ FK[2], key_i.low[31:0] ^ FK[3]};
          state_d = keys_ready_q ? ST_LOAD : ST_KEYEXP;
        end
      end
      ST_KEYEXP: begin
        rk_we = 1'b1;
        k_d   = {k_q[95:0], nk};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastRound) begin
          keys_ready_d = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rd_addr = '0;
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        rd_addr = cnt_q + 1'b1;
        x_d     = {x_q[95:0], nx};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LastRound) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.high  = {x_q[31:0], x_q[63:32]};
          out_d.low   = {x_q[95:64], x_q[127:96]};
          out_d.last  = last_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (key_clear_i) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    k_q    <= k_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  // round keys stored in decryption order
  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[LastRound - cnt_q] <= rk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[rd_addr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> keys_ready_q)
    else $error("rounds running without expanded keys");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEYEXP && cnt_q == LastRound && !key_clear_i) |=> keys_ready_q)
    else $error("keys not marked ready after expansion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |=> (state_q == ST_KEYEXP || state_q == ST_LOAD))
    else $error("taken beat did not start processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished block not moved to output register");

endmodule

/* hw/rtl/sm4_block_decrypt.sv */
// ----------------------------------------------------------------------------
// sm4_block_decrypt
// SM4 ECB block decryption with an APB key register file.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry one 128-bit ciphertext beat
// (cipher_high_i, cipher_low_i) and last_block_i. Output channel:
// out_valid_o/out_ready_i carry plain_high_o, plain_low_o and last_out_o.
// APB: key_high at 0x00, key_low at 0x08, key_enable at 0x10, 64-bit data.
// Any key register write forces a new key schedule before the next block.
// Write registers only while the block is idle.
// The single shared round unit works on one block at a time (one round a
// cycle over 32 rounds, plus load and hand-off states) and takes the next
// block only once it is idle again. The first block after reset or a key
// write also waits for the key schedule to fill the round key memory.
// A two-entry input queue keeps accepting while the engine works; a finished
// block waits in the output register while the receiver stalls, and the
// engine holds its last round until that register frees. Reset clears the
// queue, the output valid and the key-ready flag; key_enable resets to 1.
// ----------------------------------------------------------------------------
module sm4_block_decrypt #(
  parameter int QueueDepth = sm4_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sm4_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sm4_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sm4_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [63:0]                     cipher_high_i,
  input  logic [63:0]                     cipher_low_i,
  input  logic                            last_block_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [63:0]                     plain_high_o,
  output logic [63:0]                     plain_low_o,
  output logic                            last_out_o
);
  import sm4_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  logic        key_en_q;
  logic        wr_en, wr_hit;
  logic [1:0]  reg_idx;
  sm4_key_t    key;
  sm4_item_t   in_item, q_item, out_item;
  logic        q_valid, q_take;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_comb begin
    wr_hit = 1'b0;
    prdata = '0;
    case (reg_idx)
      REG_KEY_HIGH: begin
        wr_hit = wr_en;
        prdata = key_high_q;
      end
      REG_KEY_LOW: begin
        wr_hit = wr_en;
        prdata = key_low_q;
      end
      REG_KEY_EN: begin
        wr_hit = wr_en;
        prdata = {{(APB_DATA_W-1){1'b0}}, key_en_q};
      end
      default: begin
        wr_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      key_en_q   <= 1'b1;
    end else if (wr_hit) begin
      if (reg_idx == REG_KEY_HIGH) begin
        key_high_q <= pwdata;
      end
      if (reg_idx == REG_KEY_LOW) begin
        key_low_q <= pwdata;
      end
      if (reg_idx == REG_KEY_EN) begin
        key_en_q <= pwdata[0];
      end
    end
  end

  assign key.high   = key_high_q;
  assign key.low    = key_low_q;
  assign key.enable = key_en_q;

  assign in_item.high = cipher_high_i;
  assign in_item.low  = cipher_low_i;
  assign in_item.last = last_block_i;

  sm4_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .item_valid_o(q_valid),
    .item_take_i (q_take),
    .item_o      (q_item)
  );

  sm4_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .key_clear_i (wr_hit),
    .item_valid_i(q_valid),
    .item_take_o (q_take),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  assign plain_high_o = out_item.high;
  assign plain_low_o  = out_item.low;
  assign last_out_o   = out_item.last;

endmodule
